[rtl/spheroid_strip_vertex_generator_unit_macros.svh]
// assertion helpers shared by the checker
`ifndef SPHEROID_STRIP_VERTEX_GENERATOR_UNIT_MACROS_SVH
`define SPHEROID_STRIP_VERTEX_GENERATOR_UNIT_MACROS_SVH

// same-cycle implication
`define SSVG_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ssvg assertion failed");

// next-cycle implication
`define SSVG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ssvg assertion failed");

`endif

[rtl/ssvg_pkg.sv]
package ssvg_pkg;

  localparam int DIV_W     = 11;
  localparam int DIV_BITS  = 34;
  localparam int DIV_STEPS = 4;
  localparam int DIV_LAT   = (DIV_BITS + DIV_STEPS - 1) / DIV_STEPS;

  localparam int CORDIC_PER_STAGE = 2;
  localparam logic signed [32:0] CORDIC_START = 33'sd652032874;

  localparam logic [30:0] ATAN_TURN [24] = '{
    31'd536870912, 31'd316933406, 31'd167458907, 31'd85004756, 31'd42667331,
    31'd21354465, 31'd10679838, 31'd5340245, 31'd2670163, 31'd1335087,
    31'd667544, 31'd333772, 31'd166886, 31'd83443, 31'd41722, 31'd20861,
    31'd10430, 31'd5215, 31'd2608, 31'd1304, 31'd652, 31'd326, 31'd163, 31'd81
  };

  localparam logic [1:0] CFG_SEGMENTS = 2'd0;
  localparam logic [1:0] CFG_RINGS    = 2'd1;
  localparam logic [1:0] CFG_FLATTEN  = 2'd2;
  localparam logic [1:0] CFG_FLIP     = 2'd3;

  typedef struct packed {
    logic signed [31:0] sn;
    logic signed [31:0] cs;
  } sincos_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } pos_t;

  function automatic int cordic_lat(input int iters);
    return (iters + CORDIC_PER_STAGE - 1) / CORDIC_PER_STAGE + 1;
  endfunction

  // round half up, floor shift, clamp to +-1.0 in q2.14
  function automatic logic signed [15:0] round_clamp(input logic signed [63:0] v,
                                                     input int sh);
    logic signed [63:0] r;
    logic signed [15:0] res;
    r = (v + (64'sd1 <<< (sh - 1))) >>> sh;
    if (r > 64'sd16384) begin
      res = 16'sd16384;
    end else if (r < -64'sd16384) begin
      res = -16'sd16384;
    end else begin
      res = r[15:0];
    end
    return res;
  endfunction

  // q holds floor(r * 2^33 / p); nz flags a nonzero remainder
  function automatic logic [16:0] v_frac(input logic [DIV_BITS-1:0] q, input logic nz,
                                         input logic flip);
    logic [17:0] fl;
    logic [17:0] c;
    logic [18:0] a;
    fl = q[DIV_BITS-1 -: 18];
    c  = fl + 18'(((|q[DIV_BITS-19:0]) | nz));
    if (flip) begin
      a = {1'b0, fl} + 19'd1;
    end else begin
      // 1 - r/p by way of the ceiling of r/p
      a = 19'd131073 - {1'b0, c};
    end
    return a[17:1];
  endfunction

endpackage

[rtl/ssvg_div.sv]
module ssvg_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [ssvg_pkg::DIV_W-1:0]    num,
  input  logic [ssvg_pkg::DIV_W-1:0]    den,
  output logic [ssvg_pkg::DIV_BITS-1:0] quo,
  output logic                          rem_nz
);
  import ssvg_pkg::*;

  logic [DIV_W-1:0]    rem_q [DIV_LAT];
  logic [DIV_BITS-1:0] quo_q [DIV_LAT];

  for (genvar st = 0; st < DIV_LAT; st++) begin : g_st
    logic [DIV_W-1:0]    rem_in, rem_d;
    logic [DIV_BITS-1:0] quo_in, quo_d;

    if (st == 0) begin : g_first
      assign rem_in = num;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[st-1];
      assign quo_in = quo_q[st-1];
    end

    always_comb begin
      logic [DIV_W:0]      cand;
      logic [DIV_W-1:0]    r;
      logic [DIV_BITS-1:0] q;
      logic                b;
      int                  k;
      r = rem_in;
      q = quo_in;
      cand = '0;
      b = 1'b0;
      for (int j = 0; j < DIV_STEPS; j++) begin
        k = st * DIV_STEPS + j;
        if (k < DIV_BITS) begin
          // first step yields the integer bit, the rest the fraction
          cand = (k == 0) ? {1'b0, r} : {r, 1'b0};
          b = cand >= {1'b0, den};
          r = b ? DIV_W'(cand - {1'b0, den}) : cand[DIV_W-1:0];
          q = {q[DIV_BITS-2:0], b};
        end
      end
      rem_d = r;
      quo_d = q;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[st] <= rem_d;
        quo_q[st] <= quo_d;
      end
    end
  end

  assign quo    = quo_q[DIV_LAT-1];
  assign rem_nz = |rem_q[DIV_LAT-1];

endmodule

[rtl/ssvg_cordic.sv]
module ssvg_cordic #(
  parameter int ITERS = 16
) (
  input  logic              clk,
  input  logic              en,
  input  logic [31:0]       phase,
  output ssvg_pkg::sincos_t res
);
  import ssvg_pkg::*;

  localparam int NST = (ITERS + CORDIC_PER_STAGE - 1) / CORDIC_PER_STAGE;

  logic signed [32:0] x_q [NST];
  logic signed [32:0] y_q [NST];
  logic signed [32:0] z_q [NST];
  logic [1:0]         q_q [NST];

  // nearest quadrant and the residual angle
  logic [1:0]  quad;
  logic [31:0] resid;
  assign quad  = 2'(phase[31:30] + {1'b0, phase[29]});
  assign resid = phase - {quad, 30'd0};

  for (genvar st = 0; st < NST; st++) begin : g_st
    logic signed [32:0] x_in, y_in, z_in, x_d, y_d, z_d;
    logic [1:0]         q_in;

    if (st == 0) begin : g_first
      assign x_in = CORDIC_START;
      assign y_in = '0;
      assign z_in = {resid[31], resid};
      assign q_in = quad;
    end else begin : g_next
      assign x_in = x_q[st-1];
      assign y_in = y_q[st-1];
      assign z_in = z_q[st-1];
      assign q_in = q_q[st-1];
    end

    always_comb begin
      logic signed [32:0] x, y, z, dx, dy, at;
      int k;
      x = x_in;
      y = y_in;
      z = z_in;
      dx = '0;
      dy = '0;
      at = '0;
      for (int j = 0; j < CORDIC_PER_STAGE; j++) begin
        k = st * CORDIC_PER_STAGE + j;
        if (k < ITERS) begin
          dx = y >>> k;
          dy = x >>> k;
          at = signed'({2'b00, ATAN_TURN[k]});
          if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - at;
          end else begin
            x = x + dx;
            y = y - dy;
            z = z + at;
          end
        end
      end
      x_d = x;
      y_d = y;
      z_d = z;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_q[st] <= x_d;
        y_q[st] <= y_d;
        z_q[st] <= z_d;
        q_q[st] <= q_in;
      end
    end
  end

  // put the quadrant back
  logic signed [32:0] xl, yl, cs_d, sn_d;
  assign xl = x_q[NST-1];
  assign yl = y_q[NST-1];

  always_comb begin
    unique case (q_q[NST-1])
      2'd0: begin cs_d = xl;  sn_d = yl;  end
      2'd1: begin cs_d = -yl; sn_d = xl;  end
      2'd2: begin cs_d = -xl; sn_d = -yl; end
      2'd3: begin cs_d = yl;  sn_d = -xl; end
      default: begin cs_d = xl; sn_d = yl; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.cs <= cs_d[31:0];
      res.sn <= sn_d[31:0];
    end
  end

endmodule

[rtl/ssvg_vtx.sv]
module ssvg_vtx (
  input  logic              clk,
  input  logic              en,
  input  logic              flip,
  input  logic [16:0]       scale,
  input  ssvg_pkg::sincos_t row,
  input  ssvg_pkg::sincos_t seg,
  output ssvg_pkg::pos_t    pos
);
  import ssvg_pkg::*;

  logic signed [63:0] xm, ym;
  logic signed [49:0] zm;
  logic signed [31:0] sb;

  assign sb = flip ? -seg.sn : seg.sn;

  always_ff @(posedge clk) begin
    if (en) begin
      xm <= row.sn * sb;
      ym <= row.sn * seg.cs;
      zm <= row.cs * signed'({1'b0, scale});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pos.x <= round_clamp(xm, 46);
      pos.y <= round_clamp(ym, 46);
      pos.z <= round_clamp(64'(zm), 32);
    end
  end

endmodule

[rtl/spheroid_strip_vertex_generator_unit.sv]
// Triangle-strip vertex generator for an oblate UV sphere. Each input item (ring, segment)
// yields two vertices, ring t then ring t+1, except the pole start (ring 0, segment 0, not
// flipped), which yields only the lower one. The pipeline is DIV_LAT + cordic_lat + 4
// registers long ahead of the output register and takes an item in any cycle in which
// the output register is free; because the single output port carries one vertex a cycle
// while out_ready is high, an item enters only as the previous one leaves. Configuration is
// taken at once and must only change while the pipeline is empty.
module spheroid_strip_vertex_generator_unit #(
  parameter int MAX_DIVISIONS    = 1024,
  parameter int ANGLE_ITERATIONS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [9:0]         ring_index,
  input  logic [10:0]        segment_index,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] pos_x,
  output logic signed [15:0] pos_y,
  output logic signed [15:0] pos_z,
  output logic signed [15:0] norm_x,
  output logic signed [15:0] norm_y,
  output logic signed [15:0] norm_z,
  output logic [16:0]        tex_u,
  output logic [16:0]        tex_v,
  output logic               lower_row,
  output logic               run_end
);
  import ssvg_pkg::*;

  localparam int CORDIC_LAT = cordic_lat(ANGLE_ITERATIONS);
  localparam int SIDE_LAT   = CORDIC_LAT + 3;
  localparam int PIPE_LAT   = DIV_LAT + CORDIC_LAT + 4;
  // a limit beyond the register width never clamps
  localparam logic [DIV_W-1:0] MAX_DIV =
    (MAX_DIVISIONS >= (1 << DIV_W)) ? '1 : DIV_W'(MAX_DIVISIONS);

  typedef struct packed {
    logic        skip;
    logic [16:0] u;
    logic [16:0] v0;
    logic [16:0] v1;
  } side_t;

  logic [10:0] segments_around, rings_down;
  logic [15:0] flattening;
  logic        flip_inside;

  always_ff @(posedge clk) begin
    if (rst) begin
      segments_around <= 11'd32;
      rings_down      <= 11'd16;
      flattening      <= '0;
      flip_inside     <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_SEGMENTS: segments_around <= cfg_data[10:0];
        CFG_RINGS:    rings_down      <= cfg_data[10:0];
        CFG_FLATTEN:  flattening      <= cfg_data;
        CFG_FLIP:     flip_inside     <= cfg_data[0];
        default:      flip_inside     <= flip_inside;
      endcase
    end
  end

  logic [10:0] m_eff, p_eff;
  assign m_eff = (segments_around == '0) ? 11'd1 :
                 (segments_around > MAX_DIV) ? MAX_DIV : segments_around;
  assign p_eff = (rings_down == '0) ? 11'd1 :
                 (rings_down > MAX_DIV) ? MAX_DIV : rings_down;

  // pipeline control: everything moves when the output register can take a new item
  logic en;
  logic hold_vld, sel;
  assign en       = !hold_vld || (out_ready && sel);
  assign in_ready = en;

  logic vld [PIPE_LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PIPE_LAT; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int i = 1; i < PIPE_LAT; i++) vld[i] <= vld[i-1];
    end
  end

  // clamp and register the indexes
  logic [9:0]  t_q;
  logic [10:0] t1_q, s_q;
  logic [9:0]  t_cl;
  logic [10:0] s_cl;
  assign t_cl = ({1'b0, ring_index} > p_eff - 11'd1) ? 10'(p_eff - 11'd1) : ring_index;
  assign s_cl = (segment_index > m_eff) ? m_eff : segment_index;

  always_ff @(posedge clk) begin
    if (en) begin
      t_q  <= t_cl;
      t1_q <= {1'b0, t_cl} + 11'd1;
      s_q  <= s_cl;
    end
  end

  logic [DIV_BITS-1:0] qs, q0, q1;
  logic                nz0, nz1;

  ssvg_div u_div_s (
    .clk(clk), .en(en), .num(s_q), .den(m_eff), .quo(qs), .rem_nz()
  );
  ssvg_div u_div_t0 (
    .clk(clk), .en(en), .num({1'b0, t_q}), .den(p_eff), .quo(q0), .rem_nz(nz0)
  );
  ssvg_div u_div_t1 (
    .clk(clk), .en(en), .num(t1_q), .den(p_eff), .quo(q1), .rem_nz(nz1)
  );

  // rounded phases and texture fractions
  logic [31:0] phb, pha0, pha1;
  side_t       side_q [SIDE_LAT];
  logic [34:0] phb_a;
  logic [33:0] pha0_a, pha1_a;
  logic [18:0] u_a;

  assign phb_a  = {1'b0, qs} + 35'd1;
  assign pha0_a = {1'b0, q0[DIV_BITS-1:1]} + 34'd1;
  assign pha1_a = {1'b0, q1[DIV_BITS-1:1]} + 34'd1;
  assign u_a    = {1'b0, qs[DIV_BITS-1 -: 18]} + 19'd1;

  always_ff @(posedge clk) begin
    if (en) begin
      phb  <= phb_a[32:1];
      pha0 <= pha0_a[32:1];
      pha1 <= pha1_a[32:1];
      // a zero quotient means a zero index
      side_q[0].skip <= !flip_inside && (q0 == '0) && (qs == '0);
      side_q[0].u    <= u_a[17:1];
      side_q[0].v0   <= v_frac(q0, nz0, flip_inside);
      side_q[0].v1   <= v_frac(q1, nz1, flip_inside);
      for (int i = 1; i < SIDE_LAT; i++) side_q[i] <= side_q[i-1];
    end
  end

  sincos_t sc_b, sc_a0, sc_a1;

  ssvg_cordic #(.ITERS(ANGLE_ITERATIONS)) u_cordic_b (
    .clk(clk), .en(en), .phase(phb), .res(sc_b)
  );
  ssvg_cordic #(.ITERS(ANGLE_ITERATIONS)) u_cordic_a0 (
    .clk(clk), .en(en), .phase(pha0), .res(sc_a0)
  );
  ssvg_cordic #(.ITERS(ANGLE_ITERATIONS)) u_cordic_a1 (
    .clk(clk), .en(en), .phase(pha1), .res(sc_a1)
  );

  logic [16:0] scale;
  assign scale = 17'd65536 - {1'b0, flattening};

  pos_t pos0, pos1;

  ssvg_vtx u_vtx0 (
    .clk(clk), .en(en), .flip(flip_inside), .scale(scale), .row(sc_a0), .seg(sc_b),
    .pos(pos0)
  );
  ssvg_vtx u_vtx1 (
    .clk(clk), .en(en), .flip(flip_inside), .scale(scale), .row(sc_a1), .seg(sc_b),
    .pos(pos1)
  );

  // output register holds both vertices of one item
  pos_t  up_q, lo_q;
  side_t hold_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_vld <= 1'b0;
      sel      <= 1'b0;
    end else if (en) begin
      hold_vld <= vld[PIPE_LAT-1];
      sel      <= side_q[SIDE_LAT-1].skip;
    end else if (out_ready) begin
      sel <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      up_q      <= pos0;
      lo_q      <= pos1;
      hold_side <= side_q[SIDE_LAT-1];
    end
  end

  pos_t cur;
  assign cur = sel ? lo_q : up_q;

  assign out_valid = hold_vld;
  assign pos_x     = cur.x;
  assign pos_y     = cur.y;
  assign pos_z     = cur.z;
  assign norm_x    = flip_inside ? -cur.x : cur.x;
  assign norm_y    = flip_inside ? -cur.y : cur.y;
  assign norm_z    = flip_inside ? -cur.z : cur.z;
  assign tex_u     = hold_side.u;
  assign tex_v     = sel ? hold_side.v1 : hold_side.v0;
  assign lower_row = sel;
  assign run_end   = sel;

endmodule

[rtl/ssvg_checker.sv]
`include "spheroid_strip_vertex_generator_unit_macros.svh"

module ssvg_checker (
  input logic               clk,
  input logic               rst,
  input logic               cfg_write,
  input logic [1:0]         cfg_index,
  input logic [15:0]        cfg_data,
  input logic               in_valid,
  input logic               in_ready,
  input logic [9:0]         ring_index,
  input logic [10:0]        segment_index,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] pos_x,
  input logic signed [15:0] pos_y,
  input logic signed [15:0] pos_z,
  input logic signed [15:0] norm_x,
  input logic signed [15:0] norm_y,
  input logic signed [15:0] norm_z,
  input logic [16:0]        tex_u,
  input logic [16:0]        tex_v,
  input logic               lower_row,
  input logic               run_end
);

  // a stalled vertex holds
  `SSVG_ASSERT_NEXT(a_hold, out_valid && !out_ready,
    out_valid && $stable(pos_x) && $stable(tex_v) && $stable(lower_row))

  // the lower vertex follows the upper one at once
  `SSVG_ASSERT_NEXT(a_pair, out_valid && out_ready && !run_end, out_valid && lower_row)

  // the lower vertex always closes the run
  `SSVG_ASSERT_IMPL(a_end, out_valid, lower_row == run_end)

  // the pole start never shows an upper vertex
  `SSVG_ASSERT_IMPL(a_pole,
    out_valid && !lower_row && tex_u == 17'd0 && tex_v == 17'd65536,
    norm_x != pos_x || norm_y != pos_y || norm_z != pos_z)

endmodule

bind spheroid_strip_vertex_generator_unit ssvg_checker u_ssvg_checker (.*);
